/* hdl/lin_rx_pkg.sv */
`timescale 1ns / 1ps

package lin_rx_pkg;

    localparam int ID_COUNT     = 64;
    localparam int ID_W         = 6;
    localparam int LEN_W        = 4;
    localparam int BYTE_W       = 8;
    localparam int DATA_SLOTS   = 8;
    localparam int DEF_MAX_DATA = 8;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 80;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;

    typedef enum logic [1:0] {
        OP_BREAK = 2'd0,
        OP_BYTE  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_NONE   = 3'd0,
        ST_OK     = 3'd1,
        ST_CSUM   = 3'd2,
        ST_SYNC   = 3'd3,
        ST_PARITY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_BREAK = 3'd0,
        PH_SYNC  = 3'd1,
        PH_PID   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CSUM  = 3'd4
    } t_phase;

    typedef struct packed {
        logic             enhanced;
        logic [LEN_W-1:0] length;
    } t_tbl_entry;

    // standard LIN protected identifier of a 6-bit frame id
    function automatic logic [BYTE_W-1:0] pid_form(input logic [ID_W-1:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // carry-wrapped 8-bit add
    function automatic logic [BYTE_W-1:0] sum_add(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
    endfunction

endpackage

/* hdl/lin_slave_frame_receiver.sv */
`timescale 1ns / 1ps

// Channel   Dir  tuser            tdata (lowest bit first)
// s         in   opcode[1:0]      rx_byte[7:0] entry_id[5:0] entry_length[3:0]
//                                 entry_enhanced, zero pad to 24
// m         out  status[2:0]      frame_id[5:0] frame_length[3:0] data0..data7
//                                 (8 bits each), zero pad to 80
//
// One request per cycle while the output accepts results; the first stage
// reads the frame table (synchronous RAM, registered read) at the received
// byte's id and writes it for table updates; the second stage runs the phase
// logic and loads the output register. Every input request yields one result.
// Reset is synchronous; the table reads as empty via per-entry valid bits.
// A stalled output holds the second stage, which in turn holds the input.
module lin_slave_frame_receiver #(
    parameter int MAX_DATA = lin_rx_pkg::DEF_MAX_DATA
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // rx_byte, entry_id, entry_length, entry_enhanced
    input  logic [lin_rx_pkg::S_TDATA_W-1:0] i_s_tdata,
    // opcode
    input  logic [1:0]                       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // frame_id, frame_length, data0 .. data7
    output logic [lin_rx_pkg::M_TDATA_W-1:0] o_m_tdata,
    // status
    output logic [2:0]                       o_m_tuser
);
    import lin_rx_pkg::*;

    localparam int IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

    // input unpack
    logic [BYTE_W-1:0] w_in_byte;
    logic [ID_W-1:0]   w_in_id;
    t_tbl_entry        w_in_entry;
    logic              w_s_acc;

    assign w_in_byte  = i_s_tdata[7:0];
    assign w_in_id    = i_s_tdata[13:8];
    assign w_in_entry = '{enhanced: i_s_tdata[18], length: i_s_tdata[17:14]};

    // frame table
    t_tbl_entry              r_tbl_mem [ID_COUNT];
    logic [ID_COUNT-1:0]     r_tbl_vld;
    t_tbl_entry              r_tbl_rdata;
    logic                    r_tbl_hit;

    // stage 2 input
    logic              r_s1_valid;
    logic [1:0]        r_s1_op;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              w_s1_go;

    // frame state
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_frame_pid, n_frame_pid;
    logic [LEN_W-1:0]  r_want_length, n_want_length;
    logic              r_want_enh, n_want_enh;
    logic [LEN_W-1:0]  r_byte_count, n_byte_count;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_data [MAX_DATA];
    logic              w_data_we;

    // output register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;
    t_status              r_out_status, n_out_status;

    t_tbl_entry                   w_entry;
    logic                         w_len_ok;
    logic [LEN_W-1:0]             w_count_inc;
    logic [DATA_SLOTS*BYTE_W-1:0] w_rpt_bytes;

    assign w_s1_go    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_s1_go;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (w_s_acc && i_s_tuser == OP_WRITE) begin
            r_tbl_mem[w_in_id] <= w_in_entry;
        end
        if (w_s_acc) begin
            r_tbl_rdata <= r_tbl_mem[w_in_byte[ID_W-1:0]];
            r_s1_op     <= i_s_tuser;
            r_s1_byte   <= w_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld  <= '0;
            r_tbl_hit  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_tbl_hit <= r_tbl_vld[w_in_byte[ID_W-1:0]];
            end
            if (w_s_acc && i_s_tuser == OP_WRITE) begin
                r_tbl_vld[w_in_id] <= 1'b1;
            end
            if (w_s_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    assign w_entry     = r_tbl_hit ? r_tbl_rdata : '0;
    assign w_len_ok    = (w_entry.length != '0) && (w_entry.length <= LEN_W'(MAX_DATA));
    assign w_count_inc = r_byte_count + LEN_W'(1);

    // phase transitions
    always_comb begin
        n_phase = r_phase;
        if (r_s1_op == OP_BREAK) begin
            n_phase = PH_SYNC;
        end else if (r_s1_op == OP_BYTE) begin
            case (r_phase)
                PH_BREAK: begin
                    n_phase = PH_BREAK;
                end
                PH_SYNC: begin
                    n_phase = (r_s1_byte == SYNC_BYTE) ? PH_PID : PH_BREAK;
                end
                PH_PID: begin
                    if (r_s1_byte == pid_form(r_s1_byte[ID_W-1:0]) && w_len_ok) begin
                        n_phase = PH_DATA;
                    end else begin
                        n_phase = PH_BREAK;
                    end
                end
                PH_DATA: begin
                    n_phase = (w_count_inc >= r_want_length) ? PH_CSUM : PH_DATA;
                end
                default: begin
                    n_phase = PH_BREAK;
                end
            endcase
        end
    end

    // bytes visible in a frame report
    for (genvar g = 0; g < DATA_SLOTS; g++) begin : g_rpt
        if (g < MAX_DATA) begin : g_used
            assign w_rpt_bytes[g*BYTE_W +: BYTE_W] =
                (LEN_W'(g) < r_want_length) ? r_data[g] : '0;
        end else begin : g_zero
            assign w_rpt_bytes[g*BYTE_W +: BYTE_W] = '0;
        end
    end

    // datapath and result
    always_comb begin
        n_frame_pid   = r_frame_pid;
        n_want_length = r_want_length;
        n_want_enh    = r_want_enh;
        n_byte_count  = r_byte_count;
        n_sum         = r_sum;
        w_data_we     = 1'b0;
        n_out_status  = ST_NONE;
        n_out_data    = '0;
        if (r_s1_op == OP_BYTE) begin
            case (r_phase)
                PH_SYNC: begin
                    if (r_s1_byte != SYNC_BYTE) begin
                        n_out_status = ST_SYNC;
                    end
                end
                PH_PID: begin
                    if (r_s1_byte != pid_form(r_s1_byte[ID_W-1:0])) begin
                        n_out_status          = ST_PARITY;
                        n_out_data[ID_W-1:0]  = r_s1_byte[ID_W-1:0];
                    end else if (w_len_ok) begin
                        n_frame_pid   = r_s1_byte;
                        n_want_length = w_entry.length;
                        n_want_enh    = w_entry.enhanced;
                        n_byte_count  = '0;
                        n_sum         = w_entry.enhanced ? r_s1_byte : '0;
                    end
                end
                PH_DATA: begin
                    w_data_we    = 1'b1;
                    n_sum        = sum_add(r_sum, r_s1_byte);
                    n_byte_count = w_count_inc;
                end
                PH_CSUM: begin
                    n_out_status = (r_s1_byte == ~r_sum) ? ST_OK : ST_CSUM;
                    n_out_data   = M_TDATA_W'({w_rpt_bytes, r_want_length,
                                               r_frame_pid[ID_W-1:0]});
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && w_data_we) begin
            r_data[r_byte_count[IDX_W-1:0]] <= r_s1_byte;
        end
        if (w_s1_go) begin
            r_frame_pid  <= n_frame_pid;
            r_want_enh   <= n_want_enh;
            r_sum        <= n_sum;
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_BREAK;
            r_want_length <= '0;
            r_byte_count  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_s1_go) begin
                r_phase       <= n_phase;
                r_want_length <= n_want_length;
                r_byte_count  <= n_byte_count;
                r_out_valid   <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_byte_count < r_want_length)
        else $error("byte count beyond expected length");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_CSUM) |->
            (r_want_length != '0 && r_want_length <= LEN_W'(MAX_DATA)))
        else $error("frame length out of range");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_NONE) |-> o_m_tdata == '0)
        else $error("empty result carries data");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go |=> o_m_tvalid)
        else $error("processed request produced no result");
`endif

endmodule
